// ===== hdl/qrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrd_pkg
// Shared types, constants and helpers of the quadrotor rate dynamics core.
// ----------------------------------------------------------------------------
package qrd_pkg;

  // lag sub-steps per outer step
  localparam int INNER_STEPS = 50;
  localparam int ITER_W = (INNER_STEPS > 1) ? $clog2(INNER_STEPS) : 1;

  // sub-step scaling: x*dt / (65536*INNER_STEPS), rounded
  localparam logic signed [63:0] HALF_DIV = 64'(INNER_STEPS) * 64'sd32768;
  localparam int DIV_SHIFT = 42;
  localparam logic [42:0] DIV_RECIP =
    43'(((64'd1 << DIV_SHIFT) + 64'(INNER_STEPS) - 64'd1) / 64'(INNER_STEPS));

  // physical and angle constants, Q16.16
  localparam logic signed [31:0] GRAV      = 32'sd642908;
  localparam logic [18:0]        TWO_PI_Q  = 19'd411775;
  localparam logic signed [23:0] PI_Q      = 24'sd205887;
  localparam logic signed [23:0] HALF_PI_Q = 24'sd102944;

  // cordic
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_N  = 16;
  localparam int RED_STEPS = 13;
  localparam int CNT_W     = 4;

  // register indexes
  localparam logic [2:0] REG_RATE_WN   = 3'd0;
  localparam logic [2:0] REG_RATE_ZETA = 3'd1;
  localparam logic [2:0] REG_YAW_WN    = 3'd2;
  localparam logic [2:0] REG_YAW_ZETA  = 3'd3;
  localparam logic [2:0] REG_TIME_STEP = 3'd4;

  // axis and lag slots
  localparam logic [1:0] AX_ROLL   = 2'd0;
  localparam logic [1:0] AX_PITCH  = 2'd1;
  localparam logic [1:0] AX_YAW    = 2'd2;
  localparam logic [1:0] LAG_THR   = 2'd3;

  typedef enum logic {MUL_Q, MUL_DT} mul_mode_t;

  typedef struct packed {
    mul_mode_t         mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } trig_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COEF, ST_LAG, ST_ATT, ST_TRIG, ST_ACC, ST_VEL, ST_POS, ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {CS_IDLE, CS_RED, CS_ROT, CS_FIN} cordic_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [23:0] atan_at(input logic [CNT_W-1:0] i);
    case (i)
      4'd0:    return 24'sd51472;
      4'd1:    return 24'sd30386;
      4'd2:    return 24'sd16055;
      4'd3:    return 24'sd8150;
      4'd4:    return 24'sd4091;
      4'd5:    return 24'sd2047;
      4'd6:    return 24'sd1024;
      4'd7:    return 24'sd512;
      4'd8:    return 24'sd256;
      4'd9:    return 24'sd128;
      4'd10:   return 24'sd64;
      4'd11:   return 24'sd32;
      4'd12:   return 24'sd16;
      4'd13:   return 24'sd8;
      4'd14:   return 24'sd4;
      default: return 24'sd2;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/qrd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrd channel interfaces
// Command, state result and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface qrd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_cmd;
  logic signed [31:0] pitch_cmd;
  logic signed [31:0] yaw_cmd;
  logic signed [31:0] thrust_cmd;
  modport source (output valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd,
                  input ready);
  modport sink (input valid, roll_cmd, pitch_cmd, yaw_cmd, thrust_cmd,
                output ready);
endinterface

interface qrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic signed [31:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [31:0] roll_omega, pitch_omega, yaw_omega;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  roll_angle, pitch_angle, yaw_angle, roll_omega, pitch_omega, yaw_omega,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                roll_angle, pitch_angle, yaw_angle, roll_omega, pitch_omega, yaw_omega,
                output ready);
endinterface

interface qrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/qrd_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrd_mul
// Shared four-stage multiplier: Q16.16 product or sub-step dt scaling.
// ----------------------------------------------------------------------------
module qrd_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire qrd_pkg::mul_req_t req,
  output logic                   done,
  output logic signed [31:0]     result
);

  logic               vld1_r, vld2_r, vld3_r, vld4_r;
  qrd_pkg::mul_mode_t mode1_r, mode2_r, mode3_r;
  logic signed [63:0] prod;
  logic signed [63:0] prod1_r;
  logic signed [31:0] qres2_r, qres3_r;
  logic [34:0]        u2_r;
  logic               neg2_r, neg3_r;
  logic [59:0]        pl3_r;
  logic [60:0]        ph3_r;
  logic signed [63:0] q1;
  logic [79:0]        sum;
  logic [37:0]        qv;
  logic signed [63:0] sv;
  logic signed [31:0] result_r;

  assign prod = req.a * req.b;
  assign q1   = (prod1_r + qrd_pkg::HALF_DIV) >>> 16;
  assign sum  = 80'({ph3_r, 17'b0}) + 80'(pl3_r);
  assign qv   = 38'(sum >> qrd_pkg::DIV_SHIFT);
  assign sv   = neg3_r ? -$signed(64'(qv)) : $signed(64'(qv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= start;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= prod;
    mode1_r <= req.mode;
    // floor division by the sub-step count on a magnitude
    qres2_r <= qrd_pkg::sat32((prod1_r + 64'sd32768) >>> 16);
    neg2_r  <= q1[63];
    u2_r    <= q1[63] ? 35'(-q1 + 64'(qrd_pkg::INNER_STEPS) - 64'sd1) : 35'(q1);
    mode2_r <= mode1_r;
    pl3_r   <= u2_r[16:0] * qrd_pkg::DIV_RECIP;
    ph3_r   <= u2_r[34:17] * qrd_pkg::DIV_RECIP;
    neg3_r  <= neg2_r;
    qres3_r <= qres2_r;
    mode3_r <= mode2_r;
    result_r <= (mode3_r == qrd_pkg::MUL_Q) ? qres3_r : qrd_pkg::sat32(sv);
  end

  assign done   = vld4_r;
  assign result = result_r;

endmodule
`default_nettype wire

// ===== hdl/qrd_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrd_cordic
// Iterative sin/cos: angle reduction by shifted subtract, then 16 rotations.
// ----------------------------------------------------------------------------
module qrd_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output qrd_pkg::trig_t          res
);

  qrd_pkg::cordic_state_t state_r, state_nxt;
  logic [32:0]               mag_r, mag_sub, mag_nxt;
  logic                      negin_r, fold_r, fold_nxt;
  logic [qrd_pkg::CNT_W-1:0] cnt_r;
  logic signed [33:0]        x_r, y_r, xs, ys, x_nxt, y_nxt, xr, yr;
  logic signed [23:0]        z_r, z_nxt, r0, r1, rf;
  logic signed [31:0]        sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= qrd_pkg::CS_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qrd_pkg::CS_IDLE: if (start) state_nxt = qrd_pkg::CS_RED;
      qrd_pkg::CS_RED:  if (cnt_r == '0) state_nxt = qrd_pkg::CS_ROT;
      qrd_pkg::CS_ROT:  if (cnt_r == qrd_pkg::CNT_W'(qrd_pkg::CORDIC_N - 1))
                          state_nxt = qrd_pkg::CS_FIN;
      qrd_pkg::CS_FIN:  state_nxt = qrd_pkg::CS_IDLE;
      default:          state_nxt = qrd_pkg::CS_IDLE;
    endcase
  end

  // reduction step and fold into [-pi/2, pi/2]
  always_comb begin
    mag_sub = 33'(qrd_pkg::TWO_PI_Q) << cnt_r;
    mag_nxt = (mag_r >= mag_sub) ? mag_r - mag_sub : mag_r;
    r0 = (negin_r && mag_nxt != '0) ? 24'(qrd_pkg::TWO_PI_Q) - 24'(mag_nxt[18:0])
                                    : 24'(mag_nxt[18:0]);
    r1 = (r0 > qrd_pkg::PI_Q) ? r0 - 24'(qrd_pkg::TWO_PI_Q) : r0;
    fold_nxt = 1'b0;
    rf = r1;
    if (r1 > qrd_pkg::HALF_PI_Q) begin
      rf = r1 - qrd_pkg::PI_Q;
      fold_nxt = 1'b1;
    end else if (r1 < -qrd_pkg::HALF_PI_Q) begin
      rf = r1 + qrd_pkg::PI_Q;
      fold_nxt = 1'b1;
    end
  end

  // one rotation
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    if (z_r >= 0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - qrd_pkg::atan_at(cnt_r);
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + qrd_pkg::atan_at(cnt_r);
    end
    xr = (x_nxt + 34'sd8192) >>> 14;
    yr = (y_nxt + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      qrd_pkg::CS_IDLE: begin
        mag_r   <= angle[31] ? 33'(-64'(angle)) : 33'(angle);
        negin_r <= angle[31];
        cnt_r   <= qrd_pkg::CNT_W'(qrd_pkg::RED_STEPS - 1);
      end
      qrd_pkg::CS_RED: begin
        mag_r <= mag_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          z_r    <= rf;
          fold_r <= fold_nxt;
          x_r    <= qrd_pkg::CORDIC_GAIN;
          y_r    <= '0;
          cnt_r  <= '0;
        end
      end
      qrd_pkg::CS_ROT: begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        z_r   <= z_nxt;
        cnt_r <= cnt_r + 1'b1;
        cos_r <= 32'(fold_r ? -xr : xr);
        sin_r <= 32'(fold_r ? -yr : yr);
      end
      default: ;
    endcase
  end

  assign res.done  = (state_r == qrd_pkg::CS_FIN);
  assign res.sin_v = sin_r;
  assign res.cos_v = cos_r;

endmodule
`default_nettype wire

// ===== hdl/quadrotor_rate_dynamics_integrator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadrotor_rate_dynamics_integrator_core
// Rate lags, attitude, velocity and position integration on one multiplier.
// ----------------------------------------------------------------------------
//  channel   dir   word
//  in_chan   in    roll/pitch/yaw rate and thrust commands, Q16.16
//  out_chan  out   position, velocity, attitude and body rates after the step
//  cfg_chan  in    register index and value, always ready
//
//  every product goes through the shared four-stage multiplier, one operation
//  at a time (4 per lag sub-step, 24 more per word), and sin/cos through the
//  iterative cordic. in_chan is ready only in idle; the result holds until
//  out_chan takes it. synchronous active-low reset zeroes the state and loads
//  register defaults.
module quadrotor_rate_dynamics_integrator_core (
  input wire logic  clk,
  input wire logic  rst_n,
  qrd_in_if.sink    in_chan,
  qrd_out_if.source out_chan,
  qrd_cfg_if.sink   cfg_chan
);

  // config registers
  logic [22:0] rate_wn_r, yaw_wn_r;
  logic [18:0] rate_zeta_r, yaw_zeta_r;
  logic [16:0] time_step_r;

  // sequencer
  qrd_pkg::seq_state_t        state_r, state_nxt;
  logic [3:0]                 step_r, step_nxt, step_last;
  logic                       wait_r, wait_nxt;
  logic [1:0]                 lag_r, lag_nxt;
  logic [qrd_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                       mul_start, trig_start, in_take;

  // model state and temporaries
  logic signed [31:0] lag_w_r [4];
  logic signed [31:0] lag_wd_r [4];
  logic signed [31:0] cmd_r [4];
  logic signed [31:0] att_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] acc_r [3];
  logic signed [31:0] sin_r [3];
  logic signed [31:0] cos_r [3];
  logic signed [31:0] wn2_r [2];
  logic signed [31:0] damp_r [2];
  logic signed [31:0] t_r, u_r, thr_r;
  logic               ksel;
  logic signed [31:0] dt, rwn, ywn;

  qrd_pkg::mul_req_t  req;
  logic               mul_done;
  logic signed [31:0] mul_res;
  qrd_pkg::trig_t     trig;
  logic               op_done;

  assign dt  = {15'b0, time_step_r};
  assign rwn = {9'b0, rate_wn_r};
  assign ywn = {9'b0, yaw_wn_r};
  assign ksel = (lag_r == qrd_pkg::AX_YAW);
  assign in_take = in_chan.valid && in_chan.ready;

  qrd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .req    (req),
    .done   (mul_done),
    .result (mul_res)
  );

  qrd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (att_r[step_r[1:0]]),
    .res   (trig)
  );

  // register writes
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_wn_r   <= 23'd1638400;
      rate_zeta_r <= 19'd45875;
      yaw_wn_r    <= 23'd262144;
      yaw_zeta_r  <= 19'd45875;
      time_step_r <= 17'd3277;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        qrd_pkg::REG_RATE_WN:   rate_wn_r   <= cfg_chan.data[22:0];
        qrd_pkg::REG_RATE_ZETA: rate_zeta_r <= cfg_chan.data[18:0];
        qrd_pkg::REG_YAW_WN:    yaw_wn_r    <= cfg_chan.data[22:0];
        qrd_pkg::REG_YAW_ZETA:  yaw_zeta_r  <= cfg_chan.data[18:0];
        qrd_pkg::REG_TIME_STEP: time_step_r <= cfg_chan.data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrd_pkg::ST_IDLE;
      step_r  <= '0;
      wait_r  <= 1'b0;
      lag_r   <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wait_r  <= wait_nxt;
      lag_r   <= lag_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // last step of each phase
  always_comb begin
    case (state_r)
      qrd_pkg::ST_COEF: step_last = 4'd3;
      qrd_pkg::ST_LAG:  step_last = 4'd3;
      qrd_pkg::ST_ACC:  step_last = 4'd10;
      default:          step_last = 4'd2;
    endcase
  end

  assign op_done = wait_r && ((state_r == qrd_pkg::ST_TRIG) ? trig.done : mul_done);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    wait_nxt   = wait_r;
    lag_nxt    = lag_r;
    iter_nxt   = iter_r;
    mul_start  = 1'b0;
    trig_start = 1'b0;
    case (state_r)
      qrd_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = qrd_pkg::ST_COEF;
          step_nxt  = '0;
          wait_nxt  = 1'b0;
          lag_nxt   = '0;
          iter_nxt  = '0;
        end
      end
      qrd_pkg::ST_OUT: begin
        if (out_chan.ready) state_nxt = qrd_pkg::ST_IDLE;
      end
      default: begin
        if (!wait_r) begin
          // issue to the shared unit of this phase
          wait_nxt = 1'b1;
          if (state_r == qrd_pkg::ST_TRIG) trig_start = 1'b1;
          else mul_start = 1'b1;
        end else if (op_done) begin
          wait_nxt = 1'b0;
          if (step_r != step_last) begin
            step_nxt = step_r + 1'b1;
          end else begin
            step_nxt = '0;
            case (state_r)
              qrd_pkg::ST_COEF: state_nxt = qrd_pkg::ST_LAG;
              qrd_pkg::ST_LAG: begin
                if (iter_r == qrd_pkg::ITER_W'(qrd_pkg::INNER_STEPS - 1)) begin
                  iter_nxt = '0;
                  if (lag_r == qrd_pkg::LAG_THR) state_nxt = qrd_pkg::ST_ATT;
                  else lag_nxt = lag_r + 1'b1;
                end else begin
                  iter_nxt = iter_r + 1'b1;
                end
              end
              qrd_pkg::ST_ATT:  state_nxt = qrd_pkg::ST_TRIG;
              qrd_pkg::ST_TRIG: state_nxt = qrd_pkg::ST_ACC;
              qrd_pkg::ST_ACC:  state_nxt = qrd_pkg::ST_VEL;
              qrd_pkg::ST_VEL:  state_nxt = qrd_pkg::ST_POS;
              qrd_pkg::ST_POS:  state_nxt = qrd_pkg::ST_OUT;
              default:          state_nxt = qrd_pkg::ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    req.mode = qrd_pkg::MUL_Q;
    req.a    = '0;
    req.b    = '0;
    case (state_r)
      qrd_pkg::ST_COEF: begin
        case (step_r)
          4'd0:    begin req.a = rwn; req.b = rwn; end
          4'd1:    begin req.a = {13'b0, rate_zeta_r}; req.b = rwn; end
          4'd2:    begin req.a = ywn; req.b = ywn; end
          default: begin req.a = {13'b0, yaw_zeta_r}; req.b = ywn; end
        endcase
      end
      qrd_pkg::ST_LAG: begin
        case (step_r)
          4'd0: begin
            req.a = wn2_r[ksel];
            req.b = qrd_pkg::sat32(64'(cmd_r[lag_r]) - 64'(lag_w_r[lag_r]));
          end
          4'd1: begin req.a = damp_r[ksel]; req.b = lag_wd_r[lag_r]; end
          4'd2: begin req.mode = qrd_pkg::MUL_DT; req.a = t_r; req.b = dt; end
          default: begin
            req.mode = qrd_pkg::MUL_DT;
            req.a    = lag_wd_r[lag_r];
            req.b    = dt;
          end
        endcase
      end
      qrd_pkg::ST_ATT: begin req.a = lag_w_r[step_r[1:0]]; req.b = dt; end
      qrd_pkg::ST_ACC: begin
        case (step_r)
          4'd0:  begin req.a = lag_w_r[qrd_pkg::LAG_THR]; req.b = qrd_pkg::GRAV; end
          4'd1:  begin req.a = cos_r[qrd_pkg::AX_YAW]; req.b = sin_r[qrd_pkg::AX_PITCH]; end
          4'd2:  begin req.a = t_r; req.b = cos_r[qrd_pkg::AX_ROLL]; end
          4'd3:  begin req.a = sin_r[qrd_pkg::AX_YAW]; req.b = sin_r[qrd_pkg::AX_ROLL]; end
          4'd4:  begin req.a = qrd_pkg::sat32(64'(t_r) + 64'(u_r)); req.b = thr_r; end
          4'd5:  begin req.a = sin_r[qrd_pkg::AX_YAW]; req.b = sin_r[qrd_pkg::AX_PITCH]; end
          4'd6:  begin req.a = t_r; req.b = cos_r[qrd_pkg::AX_ROLL]; end
          4'd7:  begin req.a = cos_r[qrd_pkg::AX_YAW]; req.b = sin_r[qrd_pkg::AX_ROLL]; end
          4'd8:  begin req.a = qrd_pkg::sat32(64'(t_r) - 64'(u_r)); req.b = thr_r; end
          4'd9:  begin req.a = cos_r[qrd_pkg::AX_PITCH]; req.b = cos_r[qrd_pkg::AX_ROLL]; end
          default: begin req.a = t_r; req.b = thr_r; end
        endcase
      end
      qrd_pkg::ST_VEL: begin req.a = acc_r[step_r[1:0]]; req.b = dt; end
      qrd_pkg::ST_POS: begin req.a = vel_r[step_r[1:0]]; req.b = dt; end
      default: ;
    endcase
  end

  // model state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        lag_w_r[i]  <= '0;
        lag_wd_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        att_r[i] <= '0;
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (op_done) begin
      case (state_r)
        qrd_pkg::ST_LAG: begin
          if (step_r == 4'd2)
            lag_wd_r[lag_r] <= qrd_pkg::sat32(64'(lag_wd_r[lag_r]) + 64'(mul_res));
          else if (step_r == 4'd3)
            lag_w_r[lag_r] <= qrd_pkg::sat32(64'(lag_w_r[lag_r]) + 64'(mul_res));
        end
        qrd_pkg::ST_ATT:
          att_r[step_r[1:0]] <= qrd_pkg::sat32(64'(att_r[step_r[1:0]]) + 64'(mul_res));
        qrd_pkg::ST_VEL:
          vel_r[step_r[1:0]] <= qrd_pkg::sat32(64'(vel_r[step_r[1:0]]) + 64'(mul_res));
        qrd_pkg::ST_POS:
          pos_r[step_r[1:0]] <= qrd_pkg::sat32(64'(pos_r[step_r[1:0]]) + 64'(mul_res));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r[qrd_pkg::AX_ROLL]  <= in_chan.roll_cmd;
      cmd_r[qrd_pkg::AX_PITCH] <= in_chan.pitch_cmd;
      cmd_r[qrd_pkg::AX_YAW]   <= in_chan.yaw_cmd;
      cmd_r[qrd_pkg::LAG_THR]  <= in_chan.thrust_cmd;
    end
    if (op_done) begin
      case (state_r)
        qrd_pkg::ST_COEF: begin
          case (step_r)
            4'd0:    wn2_r[0]  <= mul_res;
            4'd1:    damp_r[0] <= qrd_pkg::sat32(64'(mul_res) * 64'sd2);
            4'd2:    wn2_r[1]  <= mul_res;
            default: damp_r[1] <= qrd_pkg::sat32(64'(mul_res) * 64'sd2);
          endcase
        end
        qrd_pkg::ST_LAG: begin
          if (step_r == 4'd0) t_r <= mul_res;
          else if (step_r == 4'd1) t_r <= qrd_pkg::sat32(64'(t_r) - 64'(mul_res));
        end
        qrd_pkg::ST_TRIG: begin
          sin_r[step_r[1:0]] <= trig.sin_v;
          cos_r[step_r[1:0]] <= trig.cos_v;
        end
        qrd_pkg::ST_ACC: begin
          case (step_r)
            4'd0:                 thr_r <= mul_res;
            4'd1, 4'd2, 4'd5, 4'd6, 4'd9: t_r <= mul_res;
            4'd3, 4'd7:           u_r <= mul_res;
            4'd4:                 acc_r[0] <= mul_res;
            4'd8:                 acc_r[1] <= mul_res;
            default:              acc_r[2] <= qrd_pkg::sat32(64'(mul_res) - 64'(qrd_pkg::GRAV));
          endcase
        end
        default: ;
      endcase
    end
  end

  // handshakes and result word straight from the state registers
  assign in_chan.ready  = (state_r == qrd_pkg::ST_IDLE);
  assign out_chan.valid = (state_r == qrd_pkg::ST_OUT);
  assign out_chan.pos_x = pos_r[0];
  assign out_chan.pos_y = pos_r[1];
  assign out_chan.pos_z = pos_r[2];
  assign out_chan.vel_x = vel_r[0];
  assign out_chan.vel_y = vel_r[1];
  assign out_chan.vel_z = vel_r[2];
  assign out_chan.roll_angle  = att_r[qrd_pkg::AX_ROLL];
  assign out_chan.pitch_angle = att_r[qrd_pkg::AX_PITCH];
  assign out_chan.yaw_angle   = att_r[qrd_pkg::AX_YAW];
  assign out_chan.roll_omega  = lag_w_r[qrd_pkg::AX_ROLL];
  assign out_chan.pitch_omega = lag_w_r[qrd_pkg::AX_PITCH];
  assign out_chan.yaw_omega   = lag_w_r[qrd_pkg::AX_YAW];

endmodule
`default_nettype wire
